@@ src/kal_pkg.sv @@
// Shared constants, types and helpers for the k-th ancestor engine.
package kal_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LEVELS     = 11;
	localparam int FIELD_W    = 11;
	localparam int CMD_W      = 2;
	localparam int NODE_SLOTS = MAX_NODES + 1;
	localparam int JT_DEPTH   = NODE_SLOTS * LEVELS;
	localparam int JT_AW      = $clog2(JT_DEPTH);
	localparam int PS_AW      = $clog2(NODE_SLOTS);
	localparam int LVL_W      = $clog2(LEVELS);

	localparam logic [LVL_W-1:0]   LVL_LAST     = LVL_W'(LEVELS - 1);
	localparam logic [FIELD_W-1:0] MAX_NODE_ID  = FIELD_W'(MAX_NODES);
	localparam logic [FIELD_W-1:0] NCOUNT_RST   = FIELD_W'(1024);
	// step bits at or above LEVELS make a query not-found
	localparam logic [FIELD_W-1:0] STEP_HI_MASK = FIELD_W'(~((64'd1 << LEVELS) - 64'd1));

	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic               we;
		logic [PS_AW-1:0]   waddr;
		logic [FIELD_W-1:0] wdata;
		logic [PS_AW-1:0]   raddr;
	} kal_ps_ctl_t;

	typedef struct packed {
		logic               we;
		logic [JT_AW-1:0]   waddr;
		logic [FIELD_W-1:0] wdata;
		logic [JT_AW-1:0]   raddr;
	} kal_jt_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0]   done_cmd;
		logic [FIELD_W-1:0] ancestor;
		logic               found;
	} kal_result_t;

	// jump table is level-major: level lvl starts at lvl * NODE_SLOTS
	function automatic logic [JT_AW-1:0] lvl_base(input logic [LVL_W-1:0] lvl);
		return JT_AW'(lvl * NODE_SLOTS);
	endfunction

endpackage

@@ src/kal_if.sv @@
// Request and response channel interfaces.
interface kal_req_if import kal_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [FIELD_W-1:0] node;
	logic [FIELD_W-1:0] parent_node;
	logic [FIELD_W-1:0] steps;

	modport source (output valid, cmd, node, parent_node, steps, input ready);
	modport sink (input valid, cmd, node, parent_node, steps, output ready);
endinterface

interface kal_rsp_if import kal_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   done_cmd;
	logic [FIELD_W-1:0] ancestor;
	logic               found;

	modport source (output valid, done_cmd, ancestor, found, input ready);
	modport sink (input valid, done_cmd, ancestor, found, output ready);
endinterface

@@ src/kth_ancestor_binary_lifting_top.sv @@
// Top level of the k-th ancestor engine: sequencer, parent store, jump table, output register.
//
//   channel  dir  beat contents
//   req      in   cmd, node, parent_node, steps
//   rsp      out  done_cmd, ancestor, found
//   cfg      in   node_count write (cfg_we, cfg_wdata)
//
// Loads, unknown commands and rejected queries go straight from idle to the result. A query steps
// through the LEVELS levels in turn, with one more dependent jump table read per set step bit,
// and stops early at node 0.
// A build fills level 0 from the parent store and each higher level from the one below it,
// bound by the single read port of the jump table (up to two dependent reads per higher-level entry).
// Reset clears only control state; both stores hold garbage until loaded and built.
// A finished result waits in the output register; the next request is taken meanwhile.
module kth_ancestor_binary_lifting_top import kal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	kal_req_if.sink            req,
	kal_rsp_if.source          rsp
);

	kal_ps_ctl_t        ps_ctl;
	kal_jt_ctl_t        jt_ctl;
	logic [FIELD_W-1:0] ps_rdata;
	logic [FIELD_W-1:0] jt_rdata;
	logic               push_valid;
	logic               push_ready;
	kal_result_t        push_data;

	kal_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.ps_ctl     (ps_ctl),
		.ps_rdata   (ps_rdata),
		.jt_ctl     (jt_ctl),
		.jt_rdata   (jt_rdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	kal_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (NODE_SLOTS)
	) u_parent_ram (
		.clk   (clk),
		.we    (ps_ctl.we),
		.waddr (ps_ctl.waddr),
		.wdata (ps_ctl.wdata),
		.raddr (ps_ctl.raddr),
		.rdata (ps_rdata)
	);

	kal_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (JT_DEPTH)
	) u_jump_ram (
		.clk   (clk),
		.we    (jt_ctl.we),
		.waddr (jt_ctl.waddr),
		.wdata (jt_ctl.wdata),
		.raddr (jt_ctl.raddr),
		.rdata (jt_rdata)
	);

	kal_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.rsp        (rsp)
	);

endmodule

@@ src/kal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/kal_out_stage.sv @@
// Response output register: holds one result beat until the sink takes it.
module kal_out_stage import kal_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  kal_result_t push_data,
	kal_rsp_if.source   rsp
);

	logic        valid_q;
	kal_result_t data_q;

	assign push_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			data_q <= push_data;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.done_cmd = data_q.done_cmd;
	assign rsp.ancestor = data_q.ancestor;
	assign rsp.found    = data_q.found;

endmodule

@@ src/kal_ctrl.sv @@
// Sequencer for load, table build and ancestor walk over the two stores.
module kal_ctrl import kal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	kal_req_if.sink            req,
	output kal_ps_ctl_t        ps_ctl,
	input  logic [FIELD_W-1:0] ps_rdata,
	output kal_jt_ctl_t        jt_ctl,
	input  logic [FIELD_W-1:0] jt_rdata,
	output logic               push_valid,
	input  logic               push_ready,
	output kal_result_t        push_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_B0_RD  = 4'd1;
	localparam logic [3:0] ST_B0_WR  = 4'd2;
	localparam logic [3:0] ST_BJ_A   = 4'd3;
	localparam logic [3:0] ST_BJ_B   = 4'd4;
	localparam logic [3:0] ST_BJ_C   = 4'd5;
	localparam logic [3:0] ST_Q_ISS  = 4'd6;
	localparam logic [3:0] ST_Q_WAIT = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]         state_q, state_d;
	logic [FIELD_W-1:0] ncount_q;
	logic [FIELD_W-1:0] v_q, v_d;
	logic [LVL_W-1:0]   j_q, j_d;
	logic [FIELD_W-1:0] b_q, b_d;
	logic [FIELD_W-1:0] steps_q, steps_d;
	logic [CMD_W-1:0]   cmd_q, cmd_d;
	logic [FIELD_W-1:0] cnt;
	logic               row_last, table_last, load_ok, query_ok;

	assign cnt        = (ncount_q > MAX_NODE_ID) ? MAX_NODE_ID : ncount_q;
	assign row_last   = (v_q == cnt);
	assign table_last = row_last && (j_q == LVL_LAST);
	assign load_ok    = (req.node != '0) && (req.node <= MAX_NODE_ID);
	assign query_ok   = (req.node != '0) && (req.node <= cnt)
		&& ((req.steps & STEP_HI_MASK) == '0);

	always_comb begin
		state_d = state_q;
		v_d     = v_q;
		j_d     = j_q;
		b_d     = b_q;
		steps_d = steps_q;
		cmd_d   = cmd_q;

		ps_ctl.we    = 1'b0;
		ps_ctl.waddr = PS_AW'(req.node);
		ps_ctl.wdata = req.parent_node;
		ps_ctl.raddr = PS_AW'(v_q);

		jt_ctl.we    = 1'b0;
		jt_ctl.waddr = lvl_base(j_q) + JT_AW'(v_q);
		jt_ctl.wdata = '0;
		jt_ctl.raddr = lvl_base(LVL_W'(j_q - 1'b1)) + JT_AW'(v_q);

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					cmd_d   = req.cmd;
					steps_d = req.steps;
					b_d     = '0;
					j_d     = '0;
					unique case (req.cmd)
						CMD_LOAD: begin
							ps_ctl.we = load_ok;
							state_d   = ST_DONE;
						end
						CMD_BUILD: begin
							v_d     = FIELD_W'(1);
							state_d = (cnt == '0) ? ST_DONE : ST_B0_RD;
						end
						CMD_QUERY: begin
							if (query_ok) begin
								b_d     = req.node;
								state_d = ST_Q_ISS;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_B0_RD: begin
				state_d = ST_B0_WR;
			end
			ST_B0_WR: begin
				// parents beyond the node count turn the node into a root
				jt_ctl.we    = 1'b1;
				jt_ctl.wdata = (ps_rdata > cnt) ? '0 : ps_rdata;
				if (row_last) begin
					j_d     = LVL_W'(1);
					v_d     = FIELD_W'(1);
					state_d = ST_BJ_A;
				end else begin
					v_d     = FIELD_W'(v_q + 1'b1);
					state_d = ST_B0_RD;
				end
			end
			ST_BJ_A: begin
				state_d = ST_BJ_B;
			end
			ST_BJ_B: begin
				if (jt_rdata == '0) begin
					// node 0 jumps to itself, no second read
					jt_ctl.we = 1'b1;
					if (table_last) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_BJ_A;
						if (row_last) begin
							j_d = LVL_W'(j_q + 1'b1);
							v_d = FIELD_W'(1);
						end else begin
							v_d = FIELD_W'(v_q + 1'b1);
						end
					end
				end else begin
					jt_ctl.raddr = lvl_base(LVL_W'(j_q - 1'b1)) + JT_AW'(jt_rdata);
					state_d      = ST_BJ_C;
				end
			end
			ST_BJ_C: begin
				jt_ctl.we    = 1'b1;
				jt_ctl.wdata = jt_rdata;
				if (table_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_BJ_A;
					if (row_last) begin
						j_d = LVL_W'(j_q + 1'b1);
						v_d = FIELD_W'(1);
					end else begin
						v_d = FIELD_W'(v_q + 1'b1);
					end
				end
			end
			ST_Q_ISS: begin
				jt_ctl.raddr = lvl_base(j_q) + JT_AW'(b_q);
				if (steps_q[j_q] && (b_q != '0)) begin
					state_d = ST_Q_WAIT;
				end else if ((j_q == LVL_LAST) || (b_q == '0)) begin
					state_d = ST_DONE;
				end else begin
					j_d = LVL_W'(j_q + 1'b1);
				end
			end
			ST_Q_WAIT: begin
				b_d = jt_rdata;
				if (j_q == LVL_LAST) begin
					state_d = ST_DONE;
				end else begin
					j_d     = LVL_W'(j_q + 1'b1);
					state_d = ST_Q_ISS;
				end
			end
			ST_DONE: begin
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ncount_q <= NCOUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				ncount_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_q     <= v_d;
		j_q     <= j_d;
		b_q     <= b_d;
		steps_q <= steps_d;
		cmd_q   <= cmd_d;
	end

	assign req.ready = (state_q == ST_IDLE);

	assign push_valid         = (state_q == ST_DONE);
	assign push_data.done_cmd = cmd_q;
	assign push_data.ancestor = b_q;
	assign push_data.found    = (cmd_q == CMD_QUERY) && (b_q != '0);

endmodule

@@ src/kal_checker.sv @@
// Port-level checks for the k-th ancestor engine, bound to the top level.
module kal_checker import kal_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [CMD_W-1:0]   done_cmd,
	input logic [FIELD_W-1:0] ancestor,
	input logic               found
);

	// one request in flight: the engine is busy right after a beat is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(done_cmd)
			&& $stable(ancestor) && $stable(found))
		else $error("stalled response beat changed");

	a_found_query: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> (done_cmd == CMD_QUERY) && (ancestor != '0))
		else $error("found set on a non-query or null ancestor");

	a_non_query_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (done_cmd != CMD_QUERY) |-> (ancestor == '0) && !found)
		else $error("non-query response carries an ancestor");

endmodule

bind kth_ancestor_binary_lifting_top kal_checker u_kal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.done_cmd  (rsp.done_cmd),
	.ancestor  (rsp.ancestor),
	.found     (rsp.found)
);
